@@ hw/rtl/seven_segment_scan_driver_unit_assert.svh @@
// Assertion macros shared by the scan driver checkers.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// expression holds at every edge out of reset
`define SSD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

@@ hw/rtl/ssd_pkg.sv @@
// Shared types, constants and the segment encoder for the scan driver.
// No dependencies.
package ssd_pkg;

	localparam int VALUE_W = 14;
	localparam int POINT_W = 2;
	localparam int SEG_W   = 8;
	localparam int EN_W    = 4;

	localparam logic [VALUE_W-1:0] MAX_SHOWN  = 14'd9999;
	localparam logic [SEG_W-1:0]   DOT_MASK   = 8'h7F;
	localparam logic [SEG_W-1:0]   BLANK_CODE = 8'hFF;
	localparam logic [EN_W-1:0]    ALL_OFF    = 4'hF;

	// floor(v / 10) = (v * DIV10_RECIP) >> DIV10_SHIFT for v < 43690
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POINT_W-1:0] point_position;
		logic               tick;
	} ssd_in_t;

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [EN_W-1:0]  digit_enable_n;
	} ssd_out_t;

	typedef struct packed {
		logic [VALUE_W-1:0] quot;
		logic [3:0]         rem;
	} ssd_div_t;

	// common-anode, active low, bit 7 is the point
	function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0: p = 8'hC0;
			4'd1: p = 8'hF9;
			4'd2: p = 8'hA4;
			4'd3: p = 8'hB0;
			4'd4: p = 8'h99;
			4'd5: p = 8'h92;
			4'd6: p = 8'h82;
			4'd7: p = 8'hD8;
			4'd8: p = 8'h80;
			4'd9: p = 8'h90;
			default: p = BLANK_CODE;
		endcase
		return p;
	endfunction

endpackage

@@ hw/rtl/ssd_stream_if.sv @@
// Valid/ready channel carrying one request or result payload.
// Payload type is set by the instantiating level (see ssd_pkg).
interface ssd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ hw/rtl/seven_segment_scan_driver_unit.sv @@
// Seven-segment scan driver: an accepted request is compared with the last value and point;
// when they change, every digit is converted first (one digit per cycle through the
// shared divide-by-ten unit). The result is loaded once the output is free, and ready
// returns in the same cycle as that result; no new request is taken until then.
// Async active-low reset: latches blank (0xFF / 0xF), scan phase 0, first request
// always converts.
module seven_segment_scan_driver_unit import ssd_pkg::*; #(
	parameter int NUM_DIGITS = 4
) (
	input logic          clk,
	input logic          arst_n,
	ssd_stream_if.sink   item,
	ssd_stream_if.source result
);

	localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int PH_W  = DIG_W + 1;
	localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NUM_DIGITS - 1);
	localparam logic [PH_W-1:0]  LAST_PH  = PH_W'(2 * NUM_DIGITS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [DIG_W-1:0]   cnt_q;
	logic               patterns_valid_q;
	logic [VALUE_W-1:0] last_value_q;
	logic [POINT_W-1:0] last_point_q;
	logic [PH_W-1:0]    scan_phase_q;
	logic [SEG_W-1:0]   segment_latch_q;
	logic [EN_W-1:0]    enable_latch_q;
	logic               result_valid_q;

	logic [VALUE_W-1:0] work_q;
	logic               tick_q;
	logic [SEG_W-1:0]   digit_patterns_q [NUM_DIGITS];

	logic               accept;
	logic [VALUE_W-1:0] value_clamped;
	logic               need_conv;
	ssd_div_t           div_res;
	logic               digit_keep;
	logic [SEG_W-1:0]   digit_pat;
	logic [DIG_W-1:0]   scan_k;
	logic [DIG_W-1:0]   scan_idx;
	logic [EN_W-1:0]    enable_next;
	logic               out_free;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	assign value_clamped = (item.payload.value > MAX_SHOWN) ? MAX_SHOWN : item.payload.value;
	assign need_conv     = !patterns_valid_q || (value_clamped != last_value_q)
	                       || (item.payload.point_position != last_point_q);

	ssd_div10 u_div10 (
		.dividend (work_q),
		.res      (div_res)
	);

	// keep units, any digit with a nonzero remaining value, and everything up to the point digit
	assign digit_keep = (cnt_q == '0) || (work_q != '0)
	                    || (32'(cnt_q) <= 32'(last_point_q));

	always_comb begin
		digit_pat = BLANK_CODE;
		if (digit_keep) begin
			digit_pat = seg_encode(div_res.rem);
			if ((32'(cnt_q) == 32'(last_point_q)) && (cnt_q != '0)) begin
				digit_pat = digit_pat & DOT_MASK;
			end
		end
	end

	assign scan_k   = scan_phase_q[PH_W-1:1];
	assign scan_idx = LAST_DIG - scan_k;

	always_comb begin
		enable_next = ALL_OFF;
		for (int j = 0; j < EN_W; j++) begin
			if (32'(scan_k) == j) begin
				enable_next[j] = 1'b0;
			end
		end
	end

	assign out_free = !result_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			cnt_q            <= '0;
			patterns_valid_q <= 1'b0;
			last_value_q     <= '0;
			last_point_q     <= '0;
			scan_phase_q     <= '0;
			segment_latch_q  <= BLANK_CODE;
			enable_latch_q   <= ALL_OFF;
			result_valid_q   <= 1'b0;
		end else begin
			// in ST_EMIT the emit branch owns result_valid_q
			if (result_valid_q && result.ready && (state_q != ST_EMIT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (need_conv) begin
							last_value_q     <= value_clamped;
							last_point_q     <= item.payload.point_position;
							patterns_valid_q <= 1'b1;
							cnt_q            <= '0;
							state_q          <= ST_CONV;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CONV: begin
					if (cnt_q == LAST_DIG) begin
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (!scan_phase_q[0]) begin
							segment_latch_q <= digit_patterns_q[scan_idx];
							enable_latch_q  <= enable_next;
							scan_phase_q    <= scan_phase_q + 1'b1;
						end else if (tick_q) begin
							scan_phase_q <= (scan_phase_q == LAST_PH) ? '0 : scan_phase_q + 1'b1;
						end
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_q <= value_clamped;
			tick_q <= item.payload.tick;
		end else if (state_q == ST_CONV) begin
			if (digit_keep) begin
				work_q <= div_res.quot;
			end
			digit_patterns_q[cnt_q] <= digit_pat;
		end
	end

	assign result.valid                  = result_valid_q;
	assign result.payload.segments       = segment_latch_q;
	assign result.payload.digit_enable_n = enable_latch_q;

endmodule

@@ hw/rtl/ssd_div10.sv @@
// Divide-by-ten unit: quotient and remainder of a value up to 9999.
// Uses ssd_pkg for widths and the reciprocal constant.
module ssd_div10 import ssd_pkg::*; (
	input  logic [VALUE_W-1:0] dividend,
	output ssd_div_t           res
);

	logic [VALUE_W+15:0] prod;
	logic [VALUE_W-1:0]  quot;
	logic [VALUE_W-1:0]  times_ten;
	logic [VALUE_W-1:0]  diff;

	assign prod      = {16'd0, dividend} * {{VALUE_W{1'b0}}, DIV10_RECIP};
	assign quot      = VALUE_W'(prod >> DIV10_SHIFT);
	assign times_ten = (quot << 3) + (quot << 1);
	assign diff      = dividend - times_ten;

	assign res.quot = quot;
	assign res.rem  = diff[3:0];

endmodule

@@ hw/rtl/ssd_checker.sv @@
// Port-level checker for the scan driver, bound to the scan driver module.
// Uses the assertion macros in seven_segment_scan_driver_unit_assert.svh.
`include "seven_segment_scan_driver_unit_assert.svh"

module ssd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [3:0] digit_enable_n
);

	// a result is held until taken
	`SSD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

	// not ready in the cycle after every accepted request
	`SSD_ASSERT_NEXT(a_busy_after_req, item_valid && item_ready, !item_ready, "ready right after a request")

	// never more than one digit driven
	`SSD_ASSERT_ALWAYS(a_one_digit, $onehot0(~digit_enable_n), "several digits enabled")

endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.digit_enable_n (result.payload.digit_enable_n)
);

@@ verif/ssd_display_checker.sv @@
// Scoreboard for the seven-segment scan driver: watches the request and result
// channels, predicts each scan result and compares it field by field.
// Depends on ssd_pkg for payload types and segment constants.
module ssd_display_checker import ssd_pkg::*; #(
	parameter int NUM_DIGITS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     item_ready,
	input  ssd_in_t  item_payload,
	input  logic     result_valid,
	input  logic     result_ready,
	input  ssd_out_t result_payload,
	output int       outstanding,
	output int       mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCAN_PHASES = 2 * NUM_DIGITS;
	localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hD8, 8'h80, 8'h90
	};

	// shadow of the block's display state
	logic [VALUE_W-1:0] shown_value;
	logic [POINT_W-1:0] shown_point;
	logic               glyphs_loaded;
	logic [SEG_W-1:0]   glyph [NUM_DIGITS];
	int                 scan_phase;
	logic [SEG_W-1:0]   seg_latch;
	logic [EN_W-1:0]    en_latch;

	ssd_out_t display_q [$];
	int       error_count = 0;

	assign mismatches = error_count;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		error_count++;
	endtask

	// index 0 is the units digit; leading zeros blank above the point position
	function automatic void load_glyphs(input logic [VALUE_W-1:0] v,
			input logic [POINT_W-1:0] pt);
		int rest;
		rest = v;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (i == 0 || rest > 0 || i <= int'(pt)) begin
				glyph[i] = DIGIT_GLYPH[rest % 10];
				if (i == int'(pt) && i > 0)
					glyph[i] &= DOT_MASK;
				rest /= 10;
			end else begin
				glyph[i] = BLANK_CODE;
			end
		end
	endfunction

	function automatic ssd_out_t predict_scan(input ssd_in_t req);
		logic [VALUE_W-1:0] v;
		int                 k;
		ssd_out_t           r;
		v = (req.value > MAX_SHOWN) ? MAX_SHOWN : req.value;
		if (!glyphs_loaded || v != shown_value || req.point_position != shown_point) begin
			shown_value   = v;
			shown_point   = req.point_position;
			glyphs_loaded = 1'b1;
			load_glyphs(v, req.point_position);
		end
		if (scan_phase >= SCAN_PHASES)
			scan_phase = 0;
		if (scan_phase % 2 == 0) begin
			// even phase: show display position k, leftmost first
			k         = scan_phase / 2;
			seg_latch = glyph[NUM_DIGITS-1-k];
			en_latch  = (k < EN_W) ? ~(EN_W'(1) << k) : ALL_OFF;
			scan_phase++;
		end else if (req.tick) begin
			scan_phase++;
			if (scan_phase >= SCAN_PHASES)
				scan_phase = 0;
		end
		r.segments       = seg_latch;
		r.digit_enable_n = en_latch;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ssd_out_t want;
		if (!arst_n) begin
			shown_value   = '0;
			shown_point   = '0;
			glyphs_loaded = 1'b0;
			scan_phase    = 0;
			seg_latch     = BLANK_CODE;
			en_latch      = ALL_OFF;
			display_q.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (display_q.size() == 0) begin
					report_mismatch($sformatf("result with no request pending: seg=%02h en=%01h",
						result_payload.segments, result_payload.digit_enable_n));
				end else begin
					want = display_q.pop_front();
					if (result_payload.segments !== want.segments)
						report_mismatch($sformatf("segments got %02h want %02h",
							result_payload.segments, want.segments));
					if (result_payload.digit_enable_n !== want.digit_enable_n)
						report_mismatch($sformatf("digit_enable_n got %01h want %01h",
							result_payload.digit_enable_n, want.digit_enable_n));
				end
			end
			if (item_valid && item_ready)
				display_q.push_back(predict_scan(item_payload));
			outstanding <= display_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
// Top of the scan driver testbench: clock, reset, request stimulus, result stall
// pattern, idle watchdog and the verdict. Depends on ssd_pkg, ssd_stream_if,
// seven_segment_scan_driver_unit and ssd_display_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int NUM_DIGITS   = 4;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 500;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = NUM_DIGITS + 4;

	typedef enum logic [1:0] {
		READY_STEADY,
		READY_COIN,
		READY_SPARSE
	} ready_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	int   idle_cycles = 0;
	int   outstanding;
	int   mismatches;
	int   burst_left = 0;

	ssd_stream_if #(.payload_t(ssd_in_t))  item_if ();
	ssd_stream_if #(.payload_t(ssd_out_t)) result_if ();

	always #(CLK_PERIOD / 2) clk = ~clk;

	seven_segment_scan_driver_unit #(
		.NUM_DIGITS(NUM_DIGITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_if),
		.result(result_if)
	);

	ssd_display_checker #(
		.NUM_DIGITS(NUM_DIGITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_if.valid),
		.item_ready    (item_if.ready),
		.item_payload  (item_if.payload),
		.result_valid  (result_if.valid),
		.result_ready  (result_if.ready),
		.result_payload(result_if.payload),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	function automatic ssd_in_t make_req(input int v, input int p, input bit t);
		ssd_in_t r;
		r.value          = VALUE_W'(v);
		r.point_position = POINT_W'(p);
		r.tick           = t;
		return r;
	endfunction

	// bursts of random length, random gaps between them
	task automatic issue(input ssd_in_t req);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		item_if.valid   <= 1'b1;
		item_if.payload <= req;
		do @(posedge clk); while (!item_if.ready);
	endtask

	task automatic wait_drained();
		item_if.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// receiver stall pattern, independent of the sender
	initial begin
		ready_mode_e mode;
		int          len;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = ready_mode_e'($urandom_range(0, 2));
			len  = $urandom_range(8, 40);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					READY_STEADY: result_if.ready <= 1'b1;
					READY_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
					default:      result_if.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_if.valid && item_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		ssd_in_t req;
		ssd_in_t prev;
		int      pick;
		arst_n          = 1'b0;
		item_if.valid   = 1'b0;
		item_if.payload = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// first request after reset always converts
		issue(make_req(0, 0, 0));
		issue(make_req(0, 0, 1));
		issue(make_req(9999, 3, 1));
		issue(make_req(9999, 3, 0));
		// clamps to the value already shown: no reconversion
		issue(make_req(16383, 3, 1));
		issue(make_req(10000, 1, 1));
		// zeros kept up to the point position
		issue(make_req(5, 3, 1));
		issue(make_req(5, 2, 0));
		issue(make_req(5, 1, 1));
		issue(make_req(1005, 2, 1));
		issue(make_req(1000, 0, 1));
		issue(make_req(1234, 3, 1));
		issue(make_req(5678, 2, 1));
		// odd phase holds while tick is low
		issue(make_req(90, 0, 0));
		issue(make_req(90, 0, 0));
		issue(make_req(90, 0, 1));
		issue(make_req(7, 0, 1));
		issue(make_req(8, 1, 1));
		issue(make_req(12, 0, 1));
		issue(make_req(12, 3, 1));
		issue(make_req(9999, 0, 1));
		issue(make_req(0, 3, 1));
		prev = make_req(0, 3, 1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			req  = prev;
			// about a third repeat the shown value so the no-conversion path runs
			if (pick >= 35) begin
				req.point_position = POINT_W'($urandom_range(0, 3));
				if (pick < 45)
					req.value = VALUE_W'($urandom_range(10000, 16383));
				else if (pick < 60)
					req.value = VALUE_W'($urandom_range(0, 99));
				else
					req.value = VALUE_W'($urandom_range(0, 9999));
			end
			req.tick = ($urandom_range(0, 3) != 0);
			issue(req);
			prev = req;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
